@@ src/mpbs_pkg.sv @@
// mpbs_pkg: shared types, constants and a helper function for the byte scanner.
// No dependencies.
package mpbs_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned HDR_LEN = 4;

    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_Z = 8'h5A;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5A;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    typedef enum logic [1:0] {
        HDR_NONE = 2'd0,
        HDR_PE   = 2'd1,
        HDR_ELF  = 2'd2,
        HDR_ZIP  = 2'd3
    } hdr_kind_t;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic scan;
        logic clear;
        logic load;
    } cell_ctl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

@@ src/multi_pattern_byte_scanner.sv @@
// multi_pattern_byte_scanner: top level; row of pattern cells, header check,
// output register. Depends on mpbs_pkg and mpbs_cell.
//
//  channel | dir | handshake        | payload
//  s_      | in  | s_valid/s_ready  | cmd, pattern_index, char_pos, data_byte, last
//  m_      | out | m_valid/m_ready  | string_match, header_kind, detected
//  cfg     | in  | cfg_we           | cfg_data (patterns_in_use)
//
// One request per cycle; every cell updates in the same cycle.
// A last scan byte holds input only while the output register is full and
// not taken. Reset is synchronous; no clearing pass (stores undefined until
// written).
module multi_pattern_byte_scanner #(
    parameter int unsigned NUM_PATTERNS    = 128,
    parameter int unsigned MAX_PATTERN_LEN = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [6:0] s_pattern_index,
    input  logic [5:0] s_char_pos,
    input  logic [7:0] s_data_byte,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_string_match,
    output logic [1:0] m_header_kind,
    output logic       m_detected
);
    import mpbs_pkg::*;

    localparam int unsigned POS_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int unsigned LEN_W = $clog2(MAX_PATTERN_LEN + 1);

    logic [7:0]  piu_reg;
    logic        match_reg;
    logic [31:0] hdr_reg;
    logic [2:0]  seen_reg;
    logic        mv_reg;
    logic        sm_reg;
    hdr_kind_t   hk_reg;

    logic        acc;
    logic        ld_ok;
    logic        end_scan;
    cell_ctl_t   ctl;
    logic [NUM_PATTERNS:0] chain;
    logic [31:0] hdr_next;
    logic [2:0]  seen_next;
    hdr_kind_t   hk_next;
    logic        sm_next;

    assign s_ready  = !mv_reg || m_ready || !(s_cmd == CMD_SCAN && s_last);
    assign acc      = s_valid && s_ready;
    assign ld_ok    = (32'(s_pattern_index) < NUM_PATTERNS)
                   && (32'(s_char_pos) < MAX_PATTERN_LEN);
    assign end_scan = acc && s_cmd == CMD_SCAN && s_last;

    assign ctl.scan  = acc && s_cmd == CMD_SCAN;
    assign ctl.clear = end_scan;
    assign ctl.load  = acc && s_cmd == CMD_LOAD && ld_ok;
    assign chain[0]  = match_reg;

    for (genvar i = 0; i < NUM_PATTERNS; i++) begin : g_cell
        logic sel_i;
        logic act_i;
        assign sel_i = (32'(s_pattern_index) == i);
        assign act_i = (32'(piu_reg) > i);
        mpbs_cell #(
            .LEN   (MAX_PATTERN_LEN),
            .POS_W (POS_W),
            .LEN_W (LEN_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .sel     (sel_i),
            .active  (act_i),
            .pos     (POS_W'(s_char_pos)),
            .set_len (s_last),
            .byte_in (ctl.load ? s_data_byte : fold_byte(s_data_byte)),
            .hit_in  (chain[i]),
            .hit_out (chain[i+1])
        );
    end

    always_comb begin
        hdr_next  = hdr_reg;
        seen_next = seen_reg;
        if (seen_reg < 3'(HDR_LEN)) begin
            hdr_next[8*seen_reg[1:0] +: 8] = s_data_byte;
            seen_next = seen_reg + 3'd1;
        end
        sm_next = chain[NUM_PATTERNS];
        if (seen_next < 3'(HDR_LEN)) begin
            hk_next = HDR_NONE;
        end else if (hdr_next[7:0] == CH_M && hdr_next[15:8] == CH_Z) begin
            hk_next = HDR_PE;
        end else if (hdr_next[7:0] == CH_DEL && hdr_next[15:8] == CH_E
                     && hdr_next[23:16] == CH_L && hdr_next[31:24] == CH_F) begin
            hk_next = HDR_ELF;
        end else if (hdr_next[7:0] == CH_P && hdr_next[15:8] == CH_K) begin
            hk_next = HDR_ZIP;
        end else begin
            hk_next = HDR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            piu_reg   <= '0;
            match_reg <= 1'b0;
            hdr_reg   <= '0;
            seen_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                piu_reg <= cfg_data;
            end
            if (end_scan) begin
                match_reg <= 1'b0;
                hdr_reg   <= '0;
                seen_reg  <= '0;
                mv_reg    <= 1'b1;
            end else begin
                if (ctl.scan) begin
                    match_reg <= chain[NUM_PATTERNS];
                    hdr_reg   <= hdr_next;
                    seen_reg  <= seen_next;
                end
                if (m_ready) begin
                    mv_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (end_scan) begin
            sm_reg <= sm_next;
            hk_reg <= hk_next;
        end
    end

    assign m_valid        = mv_reg;
    assign m_string_match = sm_reg;
    assign m_header_kind  = hk_reg;
    assign m_detected     = sm_reg || (hk_reg != HDR_NONE);

    a_seen_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= 3'(HDR_LEN)) else $error("bytes seen past header length");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_header_kind))
        else $error("result dropped while stalled");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        end_scan |=> seen_reg == 3'd0 && !match_reg)
        else $error("scan state not cleared");

endmodule

@@ src/mpbs_cell.sv @@
// mpbs_cell: one pattern slot; pattern bytes, length and shift-and progress.
// Depends on mpbs_pkg.
module mpbs_cell #(
    parameter int unsigned LEN    = 64,
    parameter int unsigned POS_W  = 6,
    parameter int unsigned LEN_W  = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mpbs_pkg::cell_ctl_t   ctl,
    input  logic                  sel,
    input  logic                  active,
    input  logic [POS_W-1:0]      pos,
    input  logic                  set_len,
    input  logic [7:0]            byte_in,
    input  logic                  hit_in,
    output logic                  hit_out
);
    import mpbs_pkg::*;

    logic [7:0]       pat_reg [LEN];
    logic [LEN_W-1:0] len_reg;
    logic [LEN-1:0]   prog_reg;
    logic [LEN-1:0]   prog_next;
    logic [LEN-1:0]   eq;
    logic [LEN-1:0]   lenmask;
    logic             done;

    always_comb begin
        for (int j = 0; j < LEN; j++) begin
            eq[j] = (fold_byte(pat_reg[j]) == byte_in);
            lenmask[j] = (LEN_W'(j) < len_reg);
        end
        prog_next = {prog_reg[LEN-2:0], 1'b1} & eq & lenmask;
        done = (len_reg == '0) || prog_next[POS_W'(len_reg - LEN_W'(1))];
        hit_out = hit_in | (ctl.scan & active & done);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load && sel) begin
            pat_reg[pos] <= byte_in;
            if (set_len) begin
                len_reg <= LEN_W'(pos) + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            prog_reg <= '0;
        end else if (ctl.scan) begin
            prog_reg <= prog_next;
        end
    end

endmodule

@@ tb/sv/multi_pattern_byte_scanner_tb.sv @@
// multi_pattern_byte_scanner_tb: loads pattern tables, scans byte buffers, and checks
// each scan result against a predictor. Depends on mpbs_pkg and multi_pattern_byte_scanner.
module multi_pattern_byte_scanner_tb;
    import mpbs_pkg::*;

    localparam int NPAT = 128;
    localparam int PLEN = 64;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic       cmd;
        logic [6:0] idx;
        logic [5:0] pos;
        logic [7:0] data;
        logic       last;
    } req_t;

    typedef struct packed {
        logic      sm;
        hdr_kind_t hk;
        logic      det;
    } res_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_data = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_cmd = 1'b0;
    logic [6:0] s_pattern_index = 7'd0;
    logic [5:0] s_char_pos = 6'd0;
    logic [7:0] s_data_byte = 8'd0;
    logic       s_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_string_match;
    logic [1:0] m_header_kind;
    logic       m_detected;

    multi_pattern_byte_scanner u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_pattern_index(s_pattern_index), .s_char_pos(s_char_pos),
        .s_data_byte(s_data_byte), .s_last(s_last), .m_valid(m_valid),
        .m_ready(m_ready), .m_string_match(m_string_match),
        .m_header_kind(m_header_kind), .m_detected(m_detected)
    );

    initial forever #6 aclk = ~aclk;

    // predictor state
    logic [7:0]  pat_bytes [NPAT][PLEN];
    logic [6:0]  pat_len [NPAT];
    logic [63:0] progress [NPAT];
    logic        hit;
    logic [7:0]  hdr [4];
    int          nseen;
    logic [7:0]  n_active;

    req_t pending_q[$];
    res_t scan_results_q[$];
    int   fails = 0;
    bit   hold_req = 0;
    bit   hold_used = 0;
    int   hold_cnt = 0;
    int   idle_cycles = 0;

    function automatic logic [7:0] lower(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic void predict_scan(req_t r);
        logic [63:0] eq;
        int len;
        hdr_kind_t k;
        logic [7:0] fb;
        res_t res;
        fb = lower(r.data);
        if (nseen < 4) begin
            hdr[nseen] = r.data;
            nseen++;
        end
        for (int i = 0; i < NPAT; i++) begin
            len = pat_len[i];
            eq = '0;
            for (int j = 0; j < len; j++)
                if (lower(pat_bytes[i][j]) == fb) eq[j] = 1'b1;
            progress[i] = ((progress[i] << 1) | 64'd1) & eq;
            if (i < n_active && (len == 0 || progress[i][len-1])) hit = 1'b1;
        end
        if (!r.last) return;
        k = HDR_NONE;
        if (nseen == 4) begin
            if (hdr[0] == CH_M && hdr[1] == CH_Z) k = HDR_PE;
            else if (hdr[0] == CH_DEL && hdr[1] == CH_E && hdr[2] == CH_L &&
                     hdr[3] == CH_F) k = HDR_ELF;
            else if (hdr[0] == CH_P && hdr[1] == CH_K) k = HDR_ZIP;
        end
        res = '{hit, k, hit || k != HDR_NONE};
        scan_results_q = {scan_results_q, res};
        for (int i = 0; i < NPAT; i++) progress[i] = '0;
        hit = 0;
        nseen = 0;
        hdr = '{default: 8'd0};
    endfunction

    function automatic void predict(req_t r);
        if (r.cmd == CMD_LOAD) begin
            pat_bytes[r.idx][r.pos] = r.data;
            if (r.last) pat_len[r.idx] = r.pos + 7'd1;
        end else begin
            predict_scan(r);
        end
    endfunction

    // driver: bursts and gaps
    int burst = 0, gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!(s_valid && !s_ready)) begin
                if (s_valid && s_ready) predict('{s_cmd, s_pattern_index, s_char_pos,
                                                  s_data_byte, s_last});
                if (gap > 0) begin
                    gap <= gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    req_t r;
                    r = pending_q.pop_front();
                    s_valid <= 1'b1;
                    {s_cmd, s_pattern_index, s_char_pos, s_data_byte, s_last} <= r;
                    if (burst <= 1) begin
                        burst <= $urandom_range(1, 30);
                        gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst <= burst - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern and monitor
    int rphase = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            rphase <= rphase + 1;
            if (hold_req && !hold_used) begin
                hold_cnt <= 300;
                hold_used <= 1'b1;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
            end
            m_ready <= (hold_cnt > 0) ? 1'b0 :
                       ((rphase % 64) < 32 ? 1'b1 : ($urandom_range(0, 2) != 0));
            if (m_valid && m_ready) begin
                if (scan_results_q.size() == 0) begin
                    $display("%0t: unexpected result sm=%0b hk=%0d det=%0b", $time,
                             m_string_match, m_header_kind, m_detected);
                    fails++;
                end else begin
                    res_t e;
                    e = scan_results_q.pop_front();
                    if (e.sm !== m_string_match || e.hk !== m_header_kind ||
                        e.det !== m_detected) begin
                        $display("%0t: mismatch expected sm=%0b hk=%0d det=%0b actual sm=%0b hk=%0d det=%0b",
                                 $time, e.sm, e.hk, e.det, m_string_match, m_header_kind,
                                 m_detected);
                        fails++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || hold_cnt > 0)
                idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("multi_pattern_byte_scanner test failed");
                $finish;
            end
        end
    end

    task automatic push_load(int idx, int pos, logic [7:0] b, bit lst);
        req_t r;
        r = '{CMD_LOAD, idx[6:0], pos[5:0], b, lst};
        pending_q = {pending_q, r};
    endtask

    task automatic push_scan(logic [7:0] b, bit lst);
        req_t r;
        r = '0;
        r.cmd = CMD_SCAN;
        r.idx = 7'($urandom);
        r.pos = 6'($urandom);
        r.data = b;
        r.last = lst;
        pending_q = {pending_q, r};
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || s_valid || scan_results_q.size() > 0)
            @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic set_active(logic [7:0] v);
        wait_drained();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        n_active = v > NPAT ? 8'(NPAT) : v;
    endtask

    // random character drawn mostly from a small alphabet so hits happen
    function automatic logic [7:0] rand_char();
        case ($urandom_range(0, 5))
            0: return 8'(8'h61 + $urandom_range(0, 3));
            1: return 8'(8'h41 + $urandom_range(0, 3));
            2: return 8'($urandom);
            default: return 8'(8'h61 + $urandom_range(0, 1));
        endcase
    endfunction

    task automatic load_pattern(int idx, int len);
        for (int j = 0; j < len; j++) push_load(idx, j, rand_char(), j == len - 1);
    endtask

    task automatic scan_buffer(int len);
        int hsel;
        logic [7:0] hb [4];
        hsel = $urandom_range(0, 5);
        hb = '{rand_char(), rand_char(), rand_char(), rand_char()};
        case (hsel)
            0: hb = '{CH_M, CH_Z, rand_char(), rand_char()};
            1: hb = '{CH_DEL, CH_E, CH_L, CH_F};
            2: hb = '{CH_P, CH_K, rand_char(), rand_char()};
            default: ;
        endcase
        for (int k = 0; k < len; k++)
            push_scan(k < 4 ? hb[k] : rand_char(), k == len - 1);
    endtask

    int items;
    initial begin
        for (int i = 0; i < NPAT; i++) begin
            pat_len[i] = 0;
            progress[i] = '0;
            for (int j = 0; j < PLEN; j++) pat_bytes[i][j] = 8'd0;
        end
        hit = 0;
        nseen = 0;
        hdr = '{default: 8'd0};
        n_active = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // write every entry so nothing undefined can ever be read
        for (int i = 0; i < NPAT; i++) push_load(i, 0, 8'hFF, 1'b1);
        // full-length pattern, upper-case and extreme bytes
        for (int j = 0; j < PLEN; j++) push_load(0, j, j == 63 ? 8'h5A : 8'h41, j == 63);
        load_pattern(1, 2);
        push_load(127, 0, 8'h00, 1'b1);
        set_active(8'd0);
        scan_buffer(3);
        set_active(8'd255);
        push_scan(CH_M, 0); push_scan(CH_Z, 0); push_scan(8'h00, 1);
        push_scan(CH_DEL, 0); push_scan(CH_E, 0); push_scan(CH_L, 0);
        push_scan(CH_F, 1);
        push_scan(CH_P, 0); push_scan(CH_K, 0); push_scan(8'hFF, 0); push_scan(8'h80, 1);
        push_scan(8'h00, 1);
        for (int j = 0; j < PLEN; j++) push_scan(j == 63 ? 8'h7A : 8'h61, j == 63);
        set_active(8'd128);
        set_active(8'd1);

        // pause until all results are in
        wait_drained();
        items = 0;
        while (items < 680) begin
            int op;
            op = $urandom_range(0, 19);
            if (op == 0) begin
                set_active(8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 8)));
            end else if (op < 4) begin
                int len;
                len = $urandom_range(1, 4) == 1 ? $urandom_range(1, 64) : $urandom_range(1, 4);
                load_pattern($urandom_range(0, 7) == 0 ? $urandom_range(0, 127)
                                                       : $urandom_range(0, 7), len);
                items += len;
            end else begin
                int len;
                len = $urandom_range(1, 12);
                scan_buffer(len);
                items += len;
            end
            if (items > 300) hold_req = 1;
            while (pending_q.size() > 40) @(posedge aclk);
        end
        wait_drained();
        repeat (20) @(posedge aclk);
        if (fails == 0 && scan_results_q.size() == 0)
            $display("multi_pattern_byte_scanner test passed");
        else
            $display("multi_pattern_byte_scanner test failed");
        $finish;
    end
endmodule
